[rtl/core/htd_pkg.sv]
`timescale 1ns / 1ps

package htd_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_ORDER = 5;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 12;
  localparam int ROW_W   = 5;
  localparam int MODE_W  = 2;
  localparam int ORD_W   = 3;
  localparam int LW_W    = 13;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;
  localparam int IDX_W   = 2 * MAX_ORDER;
  localparam int CMP_W   = PIX_W + IDX_W + 1;

  localparam logic [MODE_W-1:0] MODE_FIXED   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RANDOM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ORDERED = 2'd2;

  localparam logic [CIDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LEVEL  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ORDER  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd3;

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  function automatic logic [1:0] quadrant(input logic rb, input logic cb);
    logic [1:0] q;
    case ({rb, cb})
      2'b00:   q = 2'd1;
      2'b01:   q = 2'd2;
      2'b10:   q = 2'd3;
      default: q = 2'd0;
    endcase
    return q;
  endfunction

endpackage

[rtl/core/halftone_threshold_dither.sv]
`timescale 1ns / 1ps

// channel   valid      stall      payload
// pixels    pix_valid  pix_stall  pixel, random_value
// results   res_valid  res_stall  out_pixel
// config    cfg_write  -          cfg_index, cfg_data
//
// One item per clock while pix_stall is low; each result is registered.
// The decision is one compare between the input handshake and the result register.
// A skid register holds a second result, so one item is still taken while
// res_stall is high; pix_stall rises only when both are full.
// rst (synchronous) restores config, clears both counters and both valid flags.

module halftone_threshold_dither (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pix_valid,
  output logic                         pix_stall,
  input  logic [htd_pkg::PIX_W-1:0]    pixel,
  input  logic [htd_pkg::PIX_W-1:0]    random_value,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [htd_pkg::PIX_W-1:0]    out_pixel,
  input  logic                         cfg_write,
  input  logic [htd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [htd_pkg::CFG_W-1:0]    cfg_data
);
  import htd_pkg::*;

  logic [MODE_W-1:0] mode;
  logic [PIX_W-1:0]  fixed_level;
  logic [ORD_W-1:0]  matrix_order;
  logic [LW_W-1:0]   line_width;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_phase;

  logic              skid_valid;
  logic [PIX_W-1:0]  skid_pixel;

  logic [ORD_W-1:0]  order_eff;
  logic [LW_W-1:0]   width_eff;
  logic [IDX_W-1:0]  idx_full;
  logic [IDX_W-1:0]  idx;
  logic [3:0]        idx_shift;
  logic [3:0]        lhs_shift;
  logic [CMP_W-1:0]  lhs;
  logic [CMP_W-1:0]  rhs;
  logic              zero;
  logic [PIX_W-1:0]  result;
  logic              accept;
  logic              take;
  logic              row_end;

  assign pix_stall = skid_valid;
  assign accept    = pix_valid && !skid_valid;
  assign take      = res_valid && !res_stall;

  always_comb begin
    if (matrix_order == '0) begin
      order_eff = ORD_W'(1);
    end else if (matrix_order > ORD_W'(MAX_ORDER)) begin
      order_eff = ORD_W'(MAX_ORDER);
    end else begin
      order_eff = matrix_order;
    end
    if (line_width == '0) begin
      width_eff = LW_W'(1);
    end else if (line_width > LW_W'(MAX_WIDTH)) begin
      width_eff = LW_W'(MAX_WIDTH);
    end else begin
      width_eff = line_width;
    end
  end

  // level l lands at digit MAX_ORDER-1-l; levels at or above the order are shifted out
  always_comb begin
    for (int l = 0; l < MAX_ORDER; l++) begin
      idx_full[2*(MAX_ORDER-1-l) +: 2] = quadrant(row_phase[l], column_count[l]);
    end
    idx_shift = 4'(2 * (MAX_ORDER - int'(order_eff)));
    lhs_shift = 4'(2 * int'(order_eff) + 1);
    idx       = idx_full >> idx_shift;
    lhs       = CMP_W'(pixel) << lhs_shift;
    rhs       = CMP_W'({idx, 1'b1}) * CMP_W'(255);
    case (mode)
      MODE_FIXED:  zero = pixel < fixed_level;
      MODE_RANDOM: zero = pixel <= random_value;
      default:     zero = lhs <= rhs;
    endcase
    result  = zero ? PIX_BLACK : PIX_WHITE;
    row_end = ({1'b0, column_count} + LW_W'(1)) >= width_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_ORDERED;
      fixed_level  <= 8'd127;
      matrix_order <= 3'd3;
      line_width   <= 13'd750;
      column_count <= '0;
      row_phase    <= '0;
      res_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MODE:  mode         <= cfg_data[MODE_W-1:0];
          REG_LEVEL: fixed_level  <= cfg_data[PIX_W-1:0];
          REG_ORDER: matrix_order <= cfg_data[ORD_W-1:0];
          REG_WIDTH: line_width   <= cfg_data[LW_W-1:0];
          default:   ;
        endcase
      end
      if (accept) begin
        if (row_end) begin
          column_count <= '0;
          row_phase    <= row_phase + ROW_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
        end
      end
      if (take) begin
        if (skid_valid) begin
          out_pixel  <= skid_pixel;
          skid_valid <= 1'b0;
        end else begin
          res_valid <= accept;
          out_pixel <= result;
        end
      end else if (!res_valid) begin
        res_valid <= accept;
        out_pixel <= result;
      end else if (accept) begin
        skid_valid <= 1'b1;
        skid_pixel <= result;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid) else $error("skid full with empty result register");

  a_binary_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (out_pixel == PIX_BLACK || out_pixel == PIX_WHITE))
    else $error("result not binary");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && row_end |=> column_count == '0) else $error("column did not wrap");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && res_stall |=> skid_valid && res_valid)
    else $error("skid item lost while stalled");

endmodule
